// File: sv/regex_pretokenizer_split_top_macros.svh
// assertion macros for the pre-tokenizer split block
`ifndef REGEX_PRETOKENIZER_SPLIT_TOP_MACROS_SVH
`define REGEX_PRETOKENIZER_SPLIT_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RPTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpts assertion failed");

// next-cycle implication
`define RPTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpts assertion failed");

`endif

// File: sv/rpts_pkg.sv
// shared types and class codes for the pre-tokenizer split block
`timescale 1ns / 1ps
`default_nettype none

package rpts_pkg;

	localparam logic [2:0] CLS_CONTR  = 3'd0;
	localparam logic [2:0] CLS_LETTER = 3'd1;
	localparam logic [2:0] CLS_DIGIT  = 3'd2;
	localparam logic [2:0] CLS_SYMBOL = 3'd3;
	localparam logic [2:0] CLS_SPACE  = 3'd4;
	localparam logic [2:0] NO_CLASS   = 3'd7;

	// running token state
	typedef struct packed {
		logic [2:0] cls;
		logic [1:0] run;
		logic [1:0] skip;
		logic [1:0] contr;
	} st_t;

	localparam st_t ST_RESET = '{cls: NO_CLASS, run: 2'd0, skip: 2'd0, contr: 2'd0};

	// decision for one byte
	typedef struct packed {
		logic       start;
		logic [2:0] cls;
		st_t        nxt;
	} dec_t;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic [2:0] cls;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

// File: sv/rpts_decide.sv
// per-byte token decision: continue the open token or open a new one
`timescale 1ns / 1ps
`default_nettype none

module rpts_decide (
	input  rpts_pkg::st_t  st,
	input  logic [7:0]     b0,
	input  logic [7:0]     b1,
	input  logic [7:0]     b2,
	input  logic           h1,
	input  logic           h2,
	output rpts_pkg::dec_t dec
);
	import rpts_pkg::*;

	function automatic logic is_ws(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0C
			|| b == 8'h0B;
	endfunction

	function automatic logic is_let(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b[7];
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// utf-8 sequence length minus one, malformed leads count as one byte
	function automatic logic [1:0] seq_m1(input logic [7:0] b);
		logic [1:0] r;
		r = 2'd0;
		if (!b[7])
			r = 2'd0;
		else if ((b & 8'hE0) == 8'hC0)
			r = 2'd1;
		else if ((b & 8'hF0) == 8'hE0)
			r = 2'd2;
		else if ((b & 8'hF8) == 8'hF0)
			r = 2'd3;
		return r;
	endfunction

	logic       absorb;
	logic [7:0] cc;
	logic       long_contr;
	logic       short_contr;

	assign long_contr = (b1 == 8'h72 && b2 == 8'h65) || (b1 == 8'h76 && b2 == 8'h65)
		|| (b1 == 8'h6C && b2 == 8'h6C);
	assign short_contr = b1 == 8'h73 || b1 == 8'h74 || b1 == 8'h6D || b1 == 8'h64;
	assign cc = (b0 == 8'h20) ? (h1 ? b1 : 8'h20) : b0;

	always_comb begin
		dec.nxt   = st;
		dec.start = 1'b0;
		dec.cls   = st.cls;
		absorb    = 1'b0;
		case (st.cls)
			CLS_CONTR: begin
				if (st.contr != 2'd0) begin
					absorb        = 1'b1;
					dec.nxt.contr = st.contr - 2'd1;
				end
			end
			CLS_LETTER: begin
				if (st.skip != 2'd0) begin
					absorb       = 1'b1;
					dec.nxt.skip = st.skip - 2'd1;
				end else if (is_let(b0)) begin
					absorb       = 1'b1;
					dec.nxt.skip = seq_m1(b0);
				end
			end
			CLS_DIGIT: absorb = is_dig(b0);
			CLS_SYMBOL: absorb = !is_ws(b0) && !is_let(b0) && !is_dig(b0);
			CLS_SPACE: begin
				// a run of two or more leaves its last space to the next token
				if (is_ws(b0) && !(h1 && !is_ws(b1) && st.run != 2'd0)) begin
					absorb      = 1'b1;
					dec.nxt.run = (st.run == 2'd3) ? 2'd3 : st.run + 2'd1;
				end
			end
			default: absorb = 1'b0;
		endcase

		if (!absorb) begin
			dec.start     = 1'b1;
			dec.nxt.run   = 2'd0;
			dec.nxt.skip  = 2'd0;
			dec.nxt.contr = 2'd0;
			if (b0 == 8'h27 && h1 && h2 && long_contr) begin
				dec.cls       = CLS_CONTR;
				dec.nxt.contr = 2'd2;
			end else if (b0 == 8'h27 && h1 && short_contr) begin
				dec.cls       = CLS_CONTR;
				dec.nxt.contr = 2'd1;
			end else if (is_let(cc)) begin
				dec.cls = CLS_LETTER;
				if (b0 != 8'h20)
					dec.nxt.skip = seq_m1(b0);
			end else if (is_dig(cc)) begin
				dec.cls = CLS_DIGIT;
			end else if (!is_ws(cc)) begin
				dec.cls = CLS_SYMBOL;
			end else begin
				dec.cls     = CLS_SPACE;
				dec.nxt.run = 2'd1;
			end
			dec.nxt.cls = dec.cls;
		end
	end

endmodule

`default_nettype wire

// File: sv/rpts_out_skid.sv
// output register with one skid entry for result items
`timescale 1ns / 1ps
`default_nettype none

module rpts_out_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpts_pkg::res_t push_data,
	input  logic           pop_ready,
	output logic           pop_valid,
	output rpts_pkg::res_t pop_data,
	output logic           full
);
	import rpts_pkg::*;

	logic ov_q;
	logic sv_q;
	res_t od_q;
	res_t sd_q;
	logic free;

	assign free      = !ov_q || pop_ready;
	assign pop_valid = ov_q;
	assign pop_data  = od_q;
	assign full      = sv_q;

	// push only arrives while the skid entry is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (free) begin
			if (sv_q) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end else begin
				ov_q <= push;
			end
		end else if (push) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (sv_q)
				od_q <= sd_q;
			else if (push)
				od_q <= push_data;
		end else if (push) begin
			sd_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/regex_pretokenizer_split_top.sv
// top level of the byte-level regex pre-tokenizer split block
// Usage:
//   Input request: text_byte with end_of_text, taken when in_valid and in_ready.
//   Output request: out_byte, token_start, token_class, last_of_text, taken when
//   out_valid and out_ready. Every input byte comes out once, in order.
//   A byte is decided with two bytes of lookahead held in a three-entry window;
//   its result is registered once both are held and the skid entry is empty.
//   Steady throughput is one byte per cycle while the skid entry stays empty,
//   set by the single decision unit. On an end_of_text request the held bytes
//   (one to three) are flushed, one result per cycle while the skid entry is
//   empty; in_ready stays low until the flush ends.
//   The output side has a register and one skid entry: a stalled receiver
//   stops input only once the skid entry fills; nothing is lost or repeated.
//   After the last byte of a text all token state returns to its reset value.
//   Reset (arst_n low) empties the window and output stage at once and closes
//   any open token; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "regex_pretokenizer_split_top_macros.svh"

module regex_pretokenizer_split_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       token_start,
	output logic [2:0] token_class,
	output logic       last_of_text
);
	import rpts_pkg::*;

	logic [7:0] la0_q;
	logic [7:0] la1_q;
	logic [7:0] la2_q;
	logic [1:0] fill_q;
	logic       flush_q;
	st_t        st_q;

	logic       accept;
	logic       fire;
	logic       last;
	logic       h1;
	logic       h2;
	logic       skid_full;
	logic [1:0] fill_base;
	logic [7:0] n0;
	logic [7:0] n1;
	logic [7:0] n2;
	dec_t       dec;
	res_t       res;
	res_t       pop_data;

	assign fire     = !skid_full && (fill_q == 2'd3 || (flush_q && fill_q != 2'd0));
	assign in_ready = !flush_q && (fill_q != 2'd3 || !skid_full);
	assign accept   = in_valid && in_ready;
	assign h1       = fill_q >= 2'd2;
	assign h2       = fill_q == 2'd3;
	assign last     = flush_q && fill_q == 2'd1;

	rpts_decide u_decide (
		.st  (st_q),
		.b0  (la0_q),
		.b1  (la1_q),
		.b2  (la2_q),
		.h1  (h1),
		.h2  (h2),
		.dec (dec)
	);

	assign res = '{data: la0_q, start: dec.start, cls: dec.cls, last: last};

	rpts_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (res),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (pop_data),
		.full      (skid_full)
	);

	assign out_byte     = pop_data.data;
	assign token_start  = pop_data.start;
	assign token_class  = pop_data.cls;
	assign last_of_text = pop_data.last;

	// window shifts on a decision, new byte lands behind the held ones
	assign fill_base = fill_q - {1'b0, fire};

	always_comb begin
		n0 = fire ? la1_q : la0_q;
		n1 = fire ? la2_q : la1_q;
		n2 = la2_q;
		if (accept) begin
			case (fill_base)
				2'd0:    n0 = text_byte;
				2'd1:    n1 = text_byte;
				default: n2 = text_byte;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		la0_q <= n0;
		la1_q <= n1;
		la2_q <= n2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 2'd0;
			flush_q <= 1'b0;
			st_q    <= ST_RESET;
		end else begin
			fill_q <= fill_base + {1'b0, accept};
			if (fire && last) begin
				flush_q <= 1'b0;
				st_q    <= ST_RESET;
			end else begin
				if (accept && end_of_text)
					flush_q <= 1'b1;
				if (fire)
					st_q <= dec.nxt;
			end
		end
	end

	`RPTS_ASSERT_NEXT(a_eot_flushes, accept && end_of_text, flush_q && !in_ready)
	`RPTS_ASSERT_NEXT(a_last_clears, fire && last,
		fill_q == 2'd0 && !flush_q && st_q.cls == NO_CLASS)
	`RPTS_ASSERT_NOW(a_skid_behind_out, skid_full, out_valid)

endmodule

`default_nettype wire

// File: sim/regex_pretokenizer_split_checker.sv
// request monitor, byte-split predictor and result comparison for the pre-tokenizer split block
`timescale 1ns / 1ps

module regex_pretokenizer_split_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       token_start,
	input  logic [2:0] token_class,
	input  logic       last_of_text,
	output int         fail_count,
	output int         pending_count,
	output int         compared_count
);
	import rpts_pkg::*;

	localparam logic [7:0] APOS  = 8'h27;
	localparam logic [7:0] SPACE = 8'h20;

	int n_fail = 0;
	int n_pending = 0;
	int n_compared = 0;

	assign fail_count = n_fail;
	assign pending_count = n_pending;
	assign compared_count = n_compared;

	// predicted split results, oldest first
	res_t split_expect_q[$];

	// lookahead window and open token
	logic [7:0] held_byte [2];
	int         held_n;
	logic [2:0] tok_cls;
	logic [1:0] ws_run;
	logic [1:0] utf_left;
	logic [1:0] contr_left;

	function automatic bit is_space(logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0C || b == 8'h0B;
	endfunction

	function automatic bit is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b >= 8'h80;
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	// bytes that follow a utf-8 lead byte; malformed leads count as single bytes
	function automatic logic [1:0] utf_tail(logic [7:0] b);
		if (b < 8'h80) return 2'd0;
		if ((b & 8'hE0) == 8'hC0) return 2'd1;
		if ((b & 8'hF0) == 8'hE0) return 2'd2;
		if ((b & 8'hF8) == 8'hF0) return 2'd3;
		return 2'd0;
	endfunction

	task automatic clear_split();
		held_byte[0] = 8'h00;
		held_byte[1] = 8'h00;
		held_n = 0;
		tok_cls = NO_CLASS;
		ws_run = 2'd0;
		utf_left = 2'd0;
		contr_left = 2'd0;
	endtask

	task automatic open_token(input logic [7:0] b0, input bit h1, input logic [7:0] b1,
			input bit h2, input logic [7:0] b2);
		logic [7:0] lead;
		ws_run = 2'd0;
		utf_left = 2'd0;
		contr_left = 2'd0;
		if (b0 == APOS && h1) begin
			if (h2 && ((b1 == "r" && b2 == "e") || (b1 == "v" && b2 == "e") ||
					(b1 == "l" && b2 == "l"))) begin
				contr_left = 2'd2;
				tok_cls = CLS_CONTR;
				return;
			end
			if (b1 == "s" || b1 == "t" || b1 == "m" || b1 == "d") begin
				contr_left = 2'd1;
				tok_cls = CLS_CONTR;
				return;
			end
		end
		// a leading space takes the class of the byte behind it
		lead = (b0 == SPACE) ? (h1 ? b1 : SPACE) : b0;
		if (is_letter(lead)) begin
			if (b0 != SPACE)
				utf_left = utf_tail(b0);
			tok_cls = CLS_LETTER;
		end else if (is_digit(lead)) begin
			tok_cls = CLS_DIGIT;
		end else if (!is_space(lead)) begin
			tok_cls = CLS_SYMBOL;
		end else begin
			ws_run = 2'd1;
			tok_cls = CLS_SPACE;
		end
	endtask

	task automatic extend_token(input logic [7:0] b0, input bit h1, input logic [7:0] b1,
			output bit took);
		took = 1'b0;
		case (tok_cls)
			CLS_CONTR: begin
				if (contr_left != 2'd0) begin
					contr_left = contr_left - 2'd1;
					took = 1'b1;
				end
			end
			CLS_LETTER: begin
				if (utf_left != 2'd0) begin
					utf_left = utf_left - 2'd1;
					took = 1'b1;
				end else if (is_letter(b0)) begin
					utf_left = utf_tail(b0);
					took = 1'b1;
				end
			end
			CLS_DIGIT: took = is_digit(b0);
			CLS_SYMBOL: took = !is_space(b0) && !is_letter(b0) && !is_digit(b0);
			CLS_SPACE: begin
				// a run of two or more leaves its last byte to the next token
				if (is_space(b0) && !(h1 && !is_space(b1) && ws_run != 2'd0)) begin
					if (ws_run != 2'd3)
						ws_run = ws_run + 2'd1;
					took = 1'b1;
				end
			end
			default: took = 1'b0;
		endcase
	endtask

	task automatic split_byte(input logic [7:0] b0, input bit h1, input logic [7:0] b1,
			input bit h2, input logic [7:0] b2, input bit last);
		res_t r;
		bit   took;
		extend_token(b0, h1, b1, took);
		if (!took)
			open_token(b0, h1, b1, h2, b2);
		r.data = b0;
		r.start = !took;
		r.cls = tok_cls;
		r.last = last;
		split_expect_q.insert(split_expect_q.size(), r);
	endtask

	task automatic take_request(input logic [7:0] b, input bit eot);
		logic [7:0] win [4];
		int n;
		if (eot) begin
			for (int q = 0; q < held_n; q++)
				win[q] = held_byte[q];
			win[held_n] = b;
			n = held_n + 1;
			for (int q = 0; q < n; q++)
				split_byte(win[q], q + 1 < n, (q + 1 < n) ? win[q + 1] : 8'h00,
					q + 2 < n, (q + 2 < n) ? win[q + 2] : 8'h00, q == n - 1);
			clear_split();
		end else if (held_n < 2) begin
			held_byte[held_n] = b;
			held_n++;
		end else begin
			split_byte(held_byte[0], 1'b1, held_byte[1], 1'b1, b, 1'b0);
			held_byte[0] = held_byte[1];
			held_byte[1] = b;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_split();
			split_expect_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (split_expect_q.size() == 0) begin
					$display("%0t: result with nothing expected: byte %h start %b class %0d last %b",
						$time, out_byte, token_start, token_class, last_of_text);
					n_fail++;
				end else begin
					want = split_expect_q.pop_front();
					n_compared++;
					if (out_byte !== want.data || token_start !== want.start ||
							token_class !== want.cls || last_of_text !== want.last) begin
						n_fail++;
						if (out_byte !== want.data)
							$display("%0t: out_byte expected %h got %h",
								$time, want.data, out_byte);
						if (token_start !== want.start)
							$display("%0t: token_start expected %b got %b (byte %h)",
								$time, want.start, token_start, want.data);
						if (token_class !== want.cls)
							$display("%0t: token_class expected %0d got %0d (byte %h)",
								$time, want.cls, token_class, want.data);
						if (last_of_text !== want.last)
							$display("%0t: last_of_text expected %b got %b (byte %h)",
								$time, want.last, last_of_text, want.data);
					end
				end
			end
			if (in_valid && in_ready)
				take_request(text_byte, end_of_text);
		end
		n_pending = split_expect_q.size();
	end

endmodule

// File: sim/regex_pretokenizer_split_top_tb.sv
// stimulus, handshake idling and verdict for the pre-tokenizer split block
`timescale 1ns / 1ps

module regex_pretokenizer_split_top_tb;

	typedef logic [7:0] text_q_t[$];

	localparam int CYCLE_LIMIT = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       token_start;
	logic [2:0] token_class;
	logic       last_of_text;

	int split_fails;
	int split_pending;
	int split_compared;

	int cycles = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int ready_pct = 70;
	bit no_gaps = 1'b0;
	bit squeeze = 1'b0;
	bit squeezed = 1'b0;
	int hold_left = 0;
	int roll;

	regex_pretokenizer_split_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.token_start(token_start),
		.token_class(token_class),
		.last_of_text(last_of_text)
	);

	regex_pretokenizer_split_checker split_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.token_start(token_start),
		.token_class(token_class),
		.last_of_text(last_of_text),
		.fail_count(split_fails),
		.pending_count(split_pending),
		.compared_count(split_compared)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, split_pending);
			$display("FAIL regex_pretokenizer_split_top");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (squeeze && !squeezed) begin
			out_ready <= 1'b0;
			hold_left = 60;
			squeezed = 1'b1;
		end else if (ready_pct >= 100) begin
			out_ready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				out_ready <= 1'b0;
				hold_left = $urandom_range(8, 25);
			end else begin
				out_ready <= (roll < ready_pct);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input text_q_t t);
		for (int i = 0; i < t.size(); i++)
			send_byte(t[i], i == t.size() - 1);
		texts_sent++;
	endtask

	// random text built from word-like pieces, with some raw noise bytes
	task automatic make_text(output text_q_t t);
		int pieces;
		int k;
		logic [7:0] ws_set [6];
		logic [7:0] sym_set [10];
		ws_set = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};
		sym_set = '{8'h21, 8'h2C, 8'h2E, 8'h2D, 8'h3F, 8'h27, 8'h22, 8'h40, 8'h7E, 8'h5F};
		t = {};
		pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if ($urandom_range(0, 1))
						t.insert(t.size(), 8'h20);
					repeat ($urandom_range(1, 5))
						t.insert(t.size(), $urandom_range(0, 1)
							? 8'(8'h61 + $urandom_range(0, 25))
							: 8'(8'h41 + $urandom_range(0, 25)));
				end
				3: begin
					if ($urandom_range(0, 1))
						t.insert(t.size(), 8'h20);
					repeat ($urandom_range(1, 4))
						t.insert(t.size(), 8'(8'h30 + $urandom_range(0, 9)));
				end
				4: begin
					t.insert(t.size(), 8'h27);
					case ($urandom_range(0, 6))
						0: begin t.insert(t.size(), "r"); t.insert(t.size(), "e"); end
						1: begin t.insert(t.size(), "v"); t.insert(t.size(), "e"); end
						2: begin t.insert(t.size(), "l"); t.insert(t.size(), "l"); end
						3: t.insert(t.size(), "s");
						4: t.insert(t.size(), "t");
						5: t.insert(t.size(), "m");
						default: t.insert(t.size(), "d");
					endcase
				end
				5: begin
					repeat ($urandom_range(1, 4))
						t.insert(t.size(), ws_set[$urandom_range(0, 5)]);
				end
				6: begin
					repeat ($urandom_range(1, 3))
						t.insert(t.size(), sym_set[$urandom_range(0, 9)]);
				end
				7: begin
					k = $urandom_range(1, 3);
					case (k)
						1: t.insert(t.size(), 8'hC0 | 8'($urandom_range(0, 31)));
						2: t.insert(t.size(), 8'hE0 | 8'($urandom_range(0, 15)));
						default: t.insert(t.size(), 8'hF0 | 8'($urandom_range(0, 7)));
					endcase
					// occasionally cut the sequence short
					if ($urandom_range(0, 4) == 0)
						k = $urandom_range(0, k - 1);
					repeat (k)
						t.insert(t.size(), 8'h80 | 8'($urandom_range(0, 63)));
				end
				default: begin
					repeat ($urandom_range(1, 3))
						t.insert(t.size(), 8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	initial begin
		text_q_t t;
		int rand_bytes;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		text_byte <= 8'h00;
		end_of_text <= 1'b0;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 've then 'll, closed by the flush of three held bytes
		send_text('{8'h27, 8'h76, 8'h65, 8'h27, 8'h6C, 8'h6C});
		// letter, 'm, space before digits, tab run split before its last, symbol
		send_text('{8'h78, 8'h27, 8'h6D, 8'h20, 8'h34, 8'h32, 8'h09, 8'h09, 8'h09, 8'h21});
		// two-byte utf-8, malformed 0xff lead, nul symbol, lead byte cut off by end of text
		send_text('{8'hC3, 8'hA9, 8'hFF, 8'h00, 8'hE2});
		// lone space as a whole text
		send_text('{8'h20});
		// 't with a single held byte at end of text
		send_text('{8'h27, 8'h74});

		// random texts; the first ones back to back while the receiver holds off
		rand_bytes = 0;
		while (rand_bytes < 96) begin
			make_text(t);
			if (rand_bytes < 40) begin
				no_gaps = 1'b1;
				ready_pct = 70;
				squeeze = 1'b1;
			end else begin
				no_gaps = ($urandom_range(0, 4) == 0);
				ready_pct = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(40, 90);
			end
			send_text(t);
			rand_bytes += t.size();
		end
		in_valid <= 1'b0;
		ready_pct = 70;

		while (split_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d texts and %0d bytes; %0d results compared", texts_sent,
			bytes_sent, split_compared);
		$display("receiver held off for a long stretch once, idle gaps on both sides");
		if (split_fails == 0 && split_pending == 0)
			$display("PASS regex_pretokenizer_split_top");
		else
			$display("FAIL regex_pretokenizer_split_top");
		$finish;
	end

endmodule
